>>> src/aes_pkg.sv
// shared types, byte codes and parser state codes for the escape stripper
package aes_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_E         = 8'h65;
  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_BRACKET   = 8'h5B;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_stream;
  } out_beat_t;

  typedef enum logic [2:0] {
    MODE_TEXT   = 3'b001,
    MODE_START  = 3'b010,
    MODE_PARAMS = 3'b100
  } mode_t;

  typedef struct packed {
    logic      push_one;
    logic      push_two;
    out_beat_t res0;
    out_beat_t res1;
  } push_t;

  function automatic logic is_param(input logic [7:0] b);
    return ((b >= CH_ZERO) && (b <= CH_NINE)) || (b == CH_SPACE) || (b == CH_SEMI);
  endfunction

endpackage

>>> src/aes_parse.sv
// escape sequence parser: state registers and per-beat result generation
module aes_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  aes_pkg::in_beat_t beat,
  output aes_pkg::push_t    push
);
  import aes_pkg::*;

  mode_t mode;
  mode_t mode_next;
  logic  held;
  logic  held_next;
  logic  emit_bs;
  logic  emit_b;
  logic  two;

  always_comb begin
    mode_next = mode;
    held_next = held;
    emit_bs   = 1'b0;
    emit_b    = 1'b0;
    unique case (mode)
      MODE_START: begin
        if ((beat.in_byte == CH_BRACKET) || is_param(beat.in_byte)) begin
          mode_next = MODE_PARAMS;
        end else begin
          mode_next = MODE_TEXT;
        end
      end
      MODE_PARAMS: begin
        if (!is_param(beat.in_byte)) begin
          mode_next = MODE_TEXT;
        end
      end
      default: begin
        mode_next = MODE_TEXT;
        held_next = 1'b0;
        if (held && (beat.in_byte == CH_E)) begin
          mode_next = MODE_START;
        end else begin
          emit_bs = held;
          if (beat.in_byte == CH_ESC) begin
            mode_next = MODE_START;
          end else if ((beat.in_byte == CH_BACKSLASH) && !beat.last_in) begin
            held_next = 1'b1;
          end else begin
            emit_b = 1'b1;
          end
        end
      end
    endcase
    if (beat.last_in) begin
      mode_next = MODE_TEXT;
      held_next = 1'b0;
    end
  end

  assign two = emit_bs && emit_b;

  always_comb begin
    push.push_one = emit_bs || emit_b || beat.last_in;
    push.push_two = two;
    push.res1.out_byte      = beat.in_byte;
    push.res1.byte_valid    = 1'b1;
    push.res1.end_of_stream = beat.last_in;
    if (emit_bs) begin
      push.res0.out_byte   = CH_BACKSLASH;
      push.res0.byte_valid = 1'b1;
    end else if (emit_b) begin
      push.res0.out_byte   = beat.in_byte;
      push.res0.byte_valid = 1'b1;
    end else begin
      push.res0.out_byte   = 8'h00;
      push.res0.byte_valid = 1'b0;
    end
    push.res0.end_of_stream = beat.last_in && !two;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_TEXT;
      held <= 1'b0;
    end else if (step) begin
      mode <= mode_next;
      held <= held_next;
    end
  end

endmodule

>>> src/aes_outq.sv
// result queue taking one or two beats per cycle while push_en is high and handing out one unless out_stall holds it
module aes_outq (
  input  logic                      clk,
  input  logic                      rst,
  input  aes_pkg::push_t            push,
  input  logic                      push_en,
  output logic                      room_two,
  output logic                      out_valid,
  input  logic                      out_stall,
  output aes_pkg::out_beat_t        out_beat,
  output logic [aes_pkg::OUTQ_AW:0] level
);
  import aes_pkg::*;

  out_beat_t            mem [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wr_ptr;
  logic [OUTQ_AW-1:0]   rd_ptr;
  logic [OUTQ_AW:0]     count;
  logic [OUTQ_AW:0]     count_next;
  logic                 pop;
  logic                 wr_one;
  logic                 wr_two;
  logic [OUTQ_AW-1:0]   wr_ptr1;

  assign out_valid = (count != '0);
  assign out_beat  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign room_two  = (count <= (OUTQ_AW + 1)'(OUTQ_DEPTH - 2));
  assign level     = count;
  assign wr_one    = push_en && push.push_one;
  assign wr_two    = wr_one && push.push_two;
  assign wr_ptr1   = wr_ptr + OUTQ_AW'(1);

  always_comb begin
    count_next = count + (OUTQ_AW + 1)'(wr_one) + (OUTQ_AW + 1)'(wr_two)
                 - (OUTQ_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (wr_one) begin
      mem[wr_ptr] <= push.res0;
    end
    if (wr_two) begin
      mem[wr_ptr1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + OUTQ_AW'(1);
      end
      if (wr_two) begin
        wr_ptr <= wr_ptr + OUTQ_AW'(2);
      end else if (wr_one) begin
        wr_ptr <= wr_ptr1;
      end
    end
  end

endmodule

>>> src/ansi_escape_stripper_core.sv
// top level: input register, escape parser and result queue
//
//   channel | beat type  | handshake
//   in      | in_beat_t  | in_valid / in_stall
//   out     | out_beat_t | out_valid / out_stall
//
// one input beat per cycle while in_stall is low; a beat waits in the input register
// until it is parsed, and its results are written into the result queue as it is parsed
// the parser consumes a beat when the 4-entry result queue has room for two
// in_stall rises only while the queue is nearly full (the out side stalls
// or two results per beat pile up); a beat yields zero, one or two results
// synchronous reset returns the parser to text mode and empties both stages
module ansi_escape_stripper_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  aes_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output aes_pkg::out_beat_t out_beat
);
  import aes_pkg::*;

  in_beat_t          hold;
  logic              hold_full;
  logic              consume;
  logic              room_two;
  logic              take;
  push_t             push;
  logic [OUTQ_AW:0]  level;

  assign consume  = hold_full && room_two;
  assign in_stall = hold_full && !room_two;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (take) begin
      hold <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_full <= 1'b0;
    end else if (take) begin
      hold_full <= 1'b1;
    end else if (consume) begin
      hold_full <= 1'b0;
    end
  end

  aes_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (consume),
    .beat (hold),
    .push (push)
  );

  aes_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_en   (consume),
    .room_two  (room_two),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .level     (level)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= (OUTQ_AW + 1)'(OUTQ_DEPTH))
    else $error("result queue overflow");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (consume && hold.last_in) |=> out_valid)
    else $error("final beat produced no result");

  a_two_only_on_room: assert property (@(posedge clk) disable iff (rst)
    (consume && push.push_two) |-> (level <= (OUTQ_AW + 1)'(OUTQ_DEPTH - 2)))
    else $error("double push without room");

  a_stall_needs_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_full)
    else $error("stall with empty input register");

endmodule

>>> tb/stripper_checker.sv
// escape stripper checker: predicts the kept bytes of each input beat and compares result beats
module stripper_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  aes_pkg::in_beat_t  in_beat,
  input  logic               out_valid,
  input  logic               out_stall,
  input  aes_pkg::out_beat_t out_beat,
  output int                 mismatches,
  output int                 awaited,
  output int                 compared
);
  import aes_pkg::*;

  mode_t     parse_state;
  logic      bs_held;
  out_beat_t kept_q[$];
  out_beat_t want;

  function automatic logic sgr_param(input logic [7:0] b);
    return (b inside {[CH_ZERO:CH_NINE], CH_SPACE, CH_SEMI});
  endfunction

  task automatic strip_byte(input in_beat_t b);
    out_beat_t r [2];
    int        n;
    logic      plain;
    n = 0;
    plain = 1'b1;
    case (parse_state)
      MODE_START: begin
        if (b.in_byte == CH_BRACKET || sgr_param(b.in_byte)) parse_state = MODE_PARAMS;
        else parse_state = MODE_TEXT;
      end
      MODE_PARAMS: begin
        if (!sgr_param(b.in_byte)) parse_state = MODE_TEXT;
      end
      default: begin
        parse_state = MODE_TEXT;
        if (bs_held) begin
          bs_held = 1'b0;
          if (b.in_byte == CH_E) begin
            parse_state = MODE_START;
            plain = 1'b0;
          end else begin
            r[n] = '{CH_BACKSLASH, 1'b1, 1'b0};
            n++;
          end
        end
        if (plain) begin
          if (b.in_byte == CH_ESC) begin
            parse_state = MODE_START;
          end else if (b.in_byte == CH_BACKSLASH && !b.last_in) begin
            bs_held = 1'b1;
          end else begin
            r[n] = '{b.in_byte, 1'b1, 1'b0};
            n++;
          end
        end
      end
    endcase
    if (b.last_in) begin
      if (n == 0) begin
        r[0] = '{8'h00, 1'b0, 1'b0};
        n = 1;
      end
      r[n-1].end_of_stream = 1'b1;
      parse_state = MODE_TEXT;
      bs_held = 1'b0;
    end
    for (int i = 0; i < n; i++) kept_q.push_back(r[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      parse_state = MODE_TEXT;
      bs_held = 1'b0;
      kept_q.delete();
      mismatches = 0;
      compared = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (kept_q.size() == 0) begin
          $error("result beat with nothing expected: out_byte %02h", out_beat.out_byte);
          mismatches++;
        end else begin
          want = kept_q.pop_front();
          if (out_beat.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_beat.out_byte);
            mismatches++;
          end
          if (out_beat.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_beat.byte_valid);
            mismatches++;
          end
          if (out_beat.end_of_stream !== want.end_of_stream) begin
            $error("end_of_stream: expected %0b, got %0b", want.end_of_stream,
                   out_beat.end_of_stream);
            mismatches++;
          end
        end
        compared++;
      end
      if (in_valid && !in_stall) strip_byte(in_beat);
    end
    awaited = kept_q.size();
  end

endmodule

>>> tb/testbench.sv
// escape stripper testbench top: clock, reset, byte stream stimulus, output stalls and verdict
module testbench;
  import aes_pkg::*;

  localparam int PHASE_BEATS    = 700;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DIRECTED_LEN   = 26;

  localparam logic [8:0] DIRECTED [DIRECTED_LEN] = '{
    {8'h00, 1'b0}, {8'hFF, 1'b0},
    {CH_ESC, 1'b0}, {CH_BRACKET, 1'b0}, {8'h33, 1'b0}, {CH_SEMI, 1'b0}, {8'h6D, 1'b0},
    {CH_BACKSLASH, 1'b0}, {CH_E, 1'b0}, {CH_BRACKET, 1'b0}, {8'h6D, 1'b0},
    {CH_BACKSLASH, 1'b0}, {CH_BACKSLASH, 1'b0}, {CH_ESC, 1'b0}, {8'h51, 1'b0},
    {CH_ESC, 1'b0}, {CH_BRACKET, 1'b0}, {CH_BRACKET, 1'b0},
    {CH_ESC, 1'b0}, {8'h32, 1'b0}, {CH_BACKSLASH, 1'b0},
    {CH_BACKSLASH, 1'b1},
    {CH_ESC, 1'b1},
    {CH_ESC, 1'b0}, {CH_BRACKET, 1'b0}, {8'h35, 1'b1}
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  in_beat_t  in_beat = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  int mismatches;
  int awaited;
  int compared;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int beats_sent = 0;
  int streams_sent = 0;
  int quiet_cycles = 0;

  ansi_escape_stripper_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  stripper_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_beat   (out_beat),
    .mismatches (mismatches),
    .awaited    (awaited),
    .compared   (compared)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= '{b, last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (last) streams_sent++;
  endtask

  task automatic send_text_beat(input logic [7:0] b);
    send_beat(b, $urandom_range(99) < 3);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] param_byte();
    case ($urandom_range(5))
      0: return CH_SPACE;
      1: return CH_SEMI;
      default: return 8'($urandom_range(CH_ZERO, CH_NINE));
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(5))
      0: return CH_ESC;
      1: return CH_BACKSLASH;
      2: return CH_E;
      3: return CH_BRACKET;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_chunk();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 60) begin
      if ($urandom_range(1) == 1) begin
        send_text_beat(CH_ESC);
      end else begin
        send_text_beat(CH_BACKSLASH);
        send_text_beat(CH_E);
      end
      if ($urandom_range(3) != 0) send_text_beat(CH_BRACKET);
      n = $urandom_range(5);
      repeat (n) send_text_beat(param_byte());
      send_text_beat(8'($urandom_range(8'h40, 8'h7E)));
    end else if (kind < 85) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(7) == 0) send_text_beat(CH_BACKSLASH);
        else send_text_beat(8'($urandom_range(8'h20, 8'h7E)));
      end
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_text_beat(noise_byte());
    end
  endtask

  initial begin
    int first_beat;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) send_beat(DIRECTED[i][8:1], DIRECTED[i][0]);
    wait_drained();
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 71 : 0;
      sink_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 9 : 0;
      if (phase == 2) hold_asked++;
      first_beat = beats_sent;
      while (beats_sent - first_beat < PHASE_BEATS) send_random_chunk();
      wait_drained();
    end
    send_beat(8'h21, 1'b1);
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    repeat (20) @(posedge clk);
    $display("sent %0d beats in %0d streams, compared %0d result beats", beats_sent,
             streams_sent, compared);
    $display("covered escape sequences, held backslashes, noise, idle phases and a long hold");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/aes_pkg.sv
src/aes_parse.sv
src/aes_outq.sv
src/ansi_escape_stripper_core.sv
tb/stripper_checker.sv
tb/testbench.sv
